// File: rtl/rms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types, codes and helpers of the running median smoother.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int MAX_WINDOW_DEF = 31;
    localparam int WIN_W          = 5;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MODE    = 1'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 5'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       series_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       from_median;
        logic                       run_end;
        logic                       series_end;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_HEAD,
        ST_MED,
        ST_TAIL,
        ST_RAW
    } state_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HEAD,
        EMIT_MED,
        EMIT_TAIL,
        EMIT_RAW
    } emit_t;

    typedef struct packed {
        logic  load;
        logic  remove;
        logic  insert;
        logic  clear;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic fill_to_k;
        logic k2_zero;
        logic last;
        logic out_free;
        logic half_done;
        logic raw_done;
        logic fill_over;
    } status_t;

    // Map the programmed size to an odd size in 1..cap.
    function automatic logic [6:0] eff_window(input logic [WIN_W-1:0] w,
                                              input logic [6:0] cap);
        logic [6:0] v;
        v = {2'b00, w};
        if (v == 7'd0)
        begin
            v = 7'd1;
        end
        if (v[0] == 1'b0)
        begin
            v = v - 7'd1;
        end
        if (v > cap)
        begin
            v = cap;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer: update the sorted window, then emit the results of one item.
// ----------------------------------------------------------------------------
module rms_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rms_pkg::status_t sts,
    output rms_pkg::cmd_t        cmd
);

    rms_pkg::state_t state_reg;
    rms_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '{load: 1'b0, remove: 1'b0, insert: 1'b0, clear: 1'b0,
                       emit: rms_pkg::EMIT_NONE};
        unique case (state_reg)
            rms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.full ? rms_pkg::ST_REMOVE : rms_pkg::ST_INSERT;
                end
            end
            rms_pkg::ST_REMOVE:
            begin
                cmd.remove = 1'b1;
                state_next = rms_pkg::ST_INSERT;
            end
            rms_pkg::ST_INSERT:
            begin
                cmd.insert = 1'b1;
                if (sts.full)
                begin
                    state_next = rms_pkg::ST_MED;
                end
                else if (sts.fill_to_k)
                begin
                    state_next = sts.k2_zero ? rms_pkg::ST_MED : rms_pkg::ST_HEAD;
                end
                else if (sts.last)
                begin
                    state_next = rms_pkg::ST_RAW;
                end
                else
                begin
                    state_next = rms_pkg::ST_IDLE;
                end
            end
            rms_pkg::ST_HEAD:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = rms_pkg::EMIT_HEAD;
                    if (sts.half_done)
                    begin
                        state_next = rms_pkg::ST_MED;
                    end
                end
            end
            rms_pkg::ST_MED:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = rms_pkg::EMIT_MED;
                    if (sts.last && !sts.k2_zero)
                    begin
                        state_next = rms_pkg::ST_TAIL;
                    end
                    else
                    begin
                        cmd.clear  = sts.last;
                        state_next = rms_pkg::ST_IDLE;
                    end
                end
            end
            rms_pkg::ST_TAIL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = rms_pkg::EMIT_TAIL;
                    if (sts.half_done)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = rms_pkg::ST_IDLE;
                    end
                end
            end
            rms_pkg::ST_RAW:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = rms_pkg::EMIT_RAW;
                    if (sts.raw_done)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = rms_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rms_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/rms_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rms_dp
// Datapath: config registers, history ring, sorted cell row, output register.
// ----------------------------------------------------------------------------
module rms_dp #(
    parameter int MAX_WINDOW = rms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire rms_pkg::in_item_t              in_data,
    input  wire logic                           cfg_valid,
    input  wire logic [rms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rms_pkg::WIN_W-1:0]      cfg_data,
    input  wire rms_pkg::cmd_t                  cmd,
    output rms_pkg::status_t                    sts,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output rms_pkg::out_item_t                  out_data
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = rms_pkg::SAMPLE_W;
    localparam logic [6:0] CAP = 7'((MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1);

    logic [rms_pkg::WIN_W-1:0] win_reg;
    logic                      mode_reg;

    logic signed [SW-1:0] hist_reg [MAX_WINDOW];
    logic signed [SW-1:0] sval_reg [MAX_WINDOW];
    logic [AW-1:0]        sage_reg [MAX_WINDOW];

    logic [CW-1:0]        fill_reg;
    logic [CW-1:0]        k_reg;
    logic [AW-1:0]        oldest_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        tail_reg;
    logic signed [SW-1:0] x_reg;
    logic                 last_reg;

    logic                 out_valid_reg;
    rms_pkg::out_item_t   out_reg;

    logic                 full;
    logic [AW-1:0]        k2;
    logic [CW-1:0]        k2_c;
    logic [CW-1:0]        ins_cnt;
    logic [AW-1:0]        ins_age;
    logic [AW-1:0]        hist_wr;
    logic [AW-1:0]        hist_rd;
    logic signed [SW-1:0] median;
    logic signed [SW-1:0] hist_val;
    logic [AW-1:0]        oldest_inc;
    logic [CW:0]          tail_sum;
    logic [AW-1:0]        tail_start;
    logic [AW-1:0]        tail_inc;
    logic [MAX_WINDOW-1:0] gt;
    logic [MAX_WINDOW-1:0] hit;
    logic [MAX_WINDOW-1:0] after;
    logic                 out_free;
    rms_pkg::out_item_t   emit_item;

    assign full    = (fill_reg == k_reg);
    assign k2_c    = k_reg >> 1;
    assign k2      = AW'(k2_c);
    assign ins_cnt = full ? (k_reg - CW'(1)) : fill_reg;
    assign ins_age = full ? oldest_reg : AW'(fill_reg);
    assign hist_wr = ins_age;
    assign hist_rd = (cmd.emit == rms_pkg::EMIT_TAIL) ? tail_reg : idx_reg;
    assign median  = sval_reg[k2];
    assign hist_val = hist_reg[hist_rd];

    assign oldest_inc = ((CW'(oldest_reg) + CW'(1)) >= k_reg) ? '0 : (oldest_reg + AW'(1));
    assign tail_inc   = ((CW'(tail_reg) + CW'(1)) >= k_reg) ? '0 : (tail_reg + AW'(1));
    assign tail_sum   = (CW+1)'(oldest_reg) + (CW+1)'(k2_c) + (CW+1)'(1);
    assign tail_start = (tail_sum >= {1'b0, k_reg}) ? AW'(tail_sum - {1'b0, k_reg})
                                                     : AW'(tail_sum);

    assign out_free = !out_valid_reg || out_ready;

    assign sts.full      = full;
    assign sts.fill_to_k = ((fill_reg + CW'(1)) == k_reg);
    assign sts.k2_zero   = (k2_c == '0);
    assign sts.last      = last_reg;
    assign sts.out_free  = out_free;
    assign sts.half_done = ((CW'(idx_reg) + CW'(1)) == k2_c);
    assign sts.raw_done  = ((CW'(idx_reg) + CW'(1)) == fill_reg);
    assign sts.fill_over = (fill_reg > k_reg);

    // Compare each cell against the new sample, and find the leaving entry.
    always_comb
    begin
        for (int p = 0; p < MAX_WINDOW; p++)
        begin
            gt[p]  = (CW'(p) >= ins_cnt) || (sval_reg[p] > x_reg);
            hit[p] = (CW'(p) < k_reg) && (sage_reg[p] == oldest_reg);
        end
        after[0] = hit[0];
        for (int p = 1; p < MAX_WINDOW; p++)
        begin
            after[p] = after[p-1] | hit[p];
        end
    end

    always_comb
    begin
        emit_item = '{value: median, from_median: 1'b1, run_end: 1'b0, series_end: 1'b0};
        case (cmd.emit)
            rms_pkg::EMIT_HEAD:
            begin
                emit_item.value       = mode_reg ? median : hist_val;
                emit_item.from_median = mode_reg;
            end
            rms_pkg::EMIT_MED:
            begin
                emit_item.run_end    = !(last_reg && (k2_c != '0));
                emit_item.series_end = last_reg && (k2_c == '0);
            end
            rms_pkg::EMIT_TAIL:
            begin
                emit_item.value       = mode_reg ? median : hist_val;
                emit_item.from_median = mode_reg;
                emit_item.run_end     = sts.half_done;
                emit_item.series_end  = sts.half_done;
            end
            rms_pkg::EMIT_RAW:
            begin
                emit_item.value       = hist_val;
                emit_item.from_median = 1'b0;
                emit_item.run_end     = sts.raw_done;
                emit_item.series_end  = sts.raw_done;
            end
            default:
            begin
                emit_item = '{value: median, from_median: 1'b1, run_end: 1'b0,
                              series_end: 1'b0};
            end
        endcase
    end

    // Config registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= rms_pkg::WINDOW_RESET;
            mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rms_pkg::REG_WINDOW_SIZE: win_reg  <= cfg_data;
                rms_pkg::REG_END_MODE:    mode_reg <= cfg_data[0];
                default:                  win_reg  <= win_reg;
            endcase
        end
    end

    // Control counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            oldest_reg    <= '0;
            k_reg         <= CW'(3);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && (fill_reg == '0))
            begin
                k_reg <= CW'(rms_pkg::eff_window(win_reg, CAP));
            end
            if (cmd.insert)
            begin
                if (full)
                begin
                    oldest_reg <= oldest_inc;
                end
                else
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end
            if (cmd.clear)
            begin
                fill_reg   <= '0;
                oldest_reg <= '0;
            end
            if (cmd.emit != rms_pkg::EMIT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: sample latch, emit counters, history and sorted row.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= in_data.sample;
            last_reg <= in_data.series_last;
        end
        if (cmd.insert)
        begin
            hist_reg[hist_wr] <= x_reg;
        end
        if (cmd.emit != rms_pkg::EMIT_NONE)
        begin
            out_reg <= emit_item;
        end
        if (cmd.insert || (cmd.emit == rms_pkg::EMIT_MED))
        begin
            idx_reg <= '0;
        end
        else if (cmd.emit != rms_pkg::EMIT_NONE)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.emit == rms_pkg::EMIT_MED)
        begin
            tail_reg <= tail_start;
        end
        else if (cmd.emit == rms_pkg::EMIT_TAIL)
        begin
            tail_reg <= tail_inc;
        end
        for (int p = 0; p < MAX_WINDOW; p++)
        begin
            if (cmd.remove && after[p] && (p + 1 < MAX_WINDOW))
            begin
                sval_reg[p] <= sval_reg[(p + 1 < MAX_WINDOW) ? p + 1 : p];
                sage_reg[p] <= sage_reg[(p + 1 < MAX_WINDOW) ? p + 1 : p];
            end
            if (cmd.insert && gt[p])
            begin
                if (p > 0 && gt[(p > 0) ? p - 1 : 0])
                begin
                    sval_reg[p] <= sval_reg[(p > 0) ? p - 1 : 0];
                    sage_reg[p] <= sage_reg[(p > 0) ? p - 1 : 0];
                end
                else
                begin
                    sval_reg[p] <= x_reg;
                    sage_reg[p] <= ins_age;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// File: rtl/running_median_smoother_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// running_median_smoother_top
// Running median over an odd window, with raw or median values at the ends.
// ----------------------------------------------------------------------------
// One item at a time: an accepted sample is latched, the oldest entry is
// dropped from the sorted cell row (only once the window is full), the new
// sample is inserted, and then one result per cycle is emitted while the
// output side takes each transfer. The sample that fills the window also
// emits the head results, and the last sample of a series the tail results.
// The sorted row shifts all cells in parallel, so the update cost does not grow
// with the window. Results sit in an output register, so the next sample is
// taken while the last result waits.
// The window size is sampled at the first sample of each series; end mode is
// read live. Config writes are always taken (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module running_median_smoother_top #(
    parameter int MAX_WINDOW = rms_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rms_pkg::in_item_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output rms_pkg::out_item_t                 out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [rms_pkg::WIN_W-1:0]     cfg_data
);

    rms_pkg::cmd_t    cmd;
    rms_pkg::status_t sts;

    // Take config writes in any cycle.
    assign cfg_ready = 1'b1;

    rms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rms_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Hold off new samples while the current one is in work.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while previous item in work");

    // Fill count never passes the latched window size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !sts.fill_over)
        else $error("fill count above window size");

    // The end of a series is always the end of its run.
    a_series_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.series_end) |-> out_data.run_end)
        else $error("series end without run end");

    // No result is produced from an idle sequencer.
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != rms_pkg::EMIT_NONE) |-> !in_ready)
        else $error("emit while idle");

endmodule
`default_nettype wire
